>>> design/hsv_pkg.sv
package hsv_pkg;

  localparam int unsigned SectorDegrees = 60;
  localparam int unsigned SectorCount   = 9;
  localparam logic [10:0] FractionScale = 11'd1110;
  localparam logic [15:0] FractionFull  = 16'hFFFF;
  localparam logic [7:0]  LevelFull     = 8'd255;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef logic [3:0] sector_t;

  localparam sector_t SectorRedYel = 4'd0;
  localparam sector_t SectorYelGrn = 4'd1;
  localparam sector_t SectorGrnCyn = 4'd2;
  localparam sector_t SectorCynBlu = 4'd3;
  localparam sector_t SectorBluMag = 4'd4;

endpackage

>>> design/hsv_sector.sv
module hsv_sector import hsv_pkg::*; (
  input  logic [8:0] hue,
  output sector_t    sector,
  output logic [5:0] remainder
);

  logic [8:0] base;

  // sector = number of 60 degree boundaries at or below the hue
  always_comb begin
    sector = '0;
    for (int k = 1; k < SectorCount; k++) begin
      if (hue >= 9'(k * SectorDegrees)) begin
        sector = 4'(k);
      end
    end
  end

  always_comb begin
    base = '0;
    for (int k = 1; k < SectorCount; k++) begin
      if (sector == 4'(k)) begin
        base = 9'(k * SectorDegrees);
      end
    end
  end

  assign remainder = 6'(hue - base);

endmodule

>>> design/hsv_to_rgb_converter.sv
// HSV to RGB converter, four-stage pipeline.
// Throughput: one pixel per cycle while the output is not stalled;
// stages advance independently, so a stalled output fills empty
// stages before blocking the input.
// Reset: synchronous, active high; clears every stage valid bit.
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic hsv_valid,
  output logic hsv_ready,
  input  hsv_t hsv,
  output logic rgb_valid,
  input  logic rgb_ready,
  output rgb_t rgb
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  sector_t    sec_d;
  logic [5:0] rem_d;

  sector_t    sec1;
  logic [5:0] rem1;
  logic [7:0] sat1, val1;

  sector_t     sec2;
  logic [15:0] frac2, pv2;
  logic [7:0]  sat2, val2;

  sector_t    sec3;
  logic [7:0] fq3, ft3, p3, val3;
  logic       grey3;

  logic       grey4;

  logic [16:0] frac_prod;
  logic [23:0] sq_prod, st_prod;
  logic [15:0] q_prod, t_prod;
  logic [7:0]  q_lvl, t_lvl;
  rgb_t        rgb_next;

  assign rdy4 = !v4 || rgb_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign hsv_ready = rdy1;
  assign rgb_valid = v4;

  hsv_sector u_sector (
    .hue       (hsv.hue),
    .sector    (sec_d),
    .remainder (rem_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= hsv_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: sector and remainder
  always_ff @(posedge clk) begin
    if (rdy1) begin
      sec1 <= sec_d;
      rem1 <= rem_d;
      sat1 <= hsv.saturation;
      val1 <= hsv.brightness;
    end
  end

  // stage 2: fraction and p product
  assign frac_prod = rem1 * FractionScale;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sec2  <= sec1;
      frac2 <= frac_prod[15:0];
      pv2   <= val1 * (LevelFull - sat1);
      sat2  <= sat1;
      val2  <= val1;
    end
  end

  // stage 3: scaled saturation terms for q and t
  assign sq_prod = sat2 * frac2;
  assign st_prod = sat2 * (FractionFull - frac2);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sec3  <= sec2;
      fq3   <= sq_prod[23:16];
      ft3   <= st_prod[23:16];
      p3    <= pv2[15:8];
      val3  <= val2;
      grey3 <= (sat2 == 8'd0);
    end
  end

  // stage 4: q, t and channel select
  assign q_prod = val3 * (LevelFull - fq3);
  assign t_prod = val3 * (LevelFull - ft3);
  assign q_lvl  = q_prod[15:8];
  assign t_lvl  = t_prod[15:8];

  always_comb begin
    if (grey3) begin
      rgb_next = '{red: val3, green: val3, blue: val3};
    end else begin
      case (sec3)
        SectorRedYel: rgb_next = '{red: val3,  green: t_lvl, blue: p3};
        SectorYelGrn: rgb_next = '{red: q_lvl, green: val3,  blue: p3};
        SectorGrnCyn: rgb_next = '{red: p3,    green: val3,  blue: t_lvl};
        SectorCynBlu: rgb_next = '{red: p3,    green: q_lvl, blue: val3};
        SectorBluMag: rgb_next = '{red: t_lvl, green: p3,    blue: val3};
        default:      rgb_next = '{red: val3,  green: p3,    blue: q_lvl};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      rgb   <= rgb_next;
      grey4 <= grey3;
    end
  end

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> hsv_ready)
    else $error("input blocked with empty output stage");

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && grey4) |-> (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("grey pixel with unequal channels");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rgb_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && rgb_valid && !rgb_ready) |=> v3)
    else $error("stage 3 lost an item under stall");

endmodule
